[hdl/ffba_pkg.sv]
// Package: defaults and status codes of the first-fit block allocator.
`default_nettype none
package ffba_pkg;
	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 24;
	localparam int ADDR_W = 12;
	localparam int SIZE_W = 12;
	localparam int STAT_W = 3;

	localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE     = 3'd2;
	localparam logic [STAT_W-1:0] ST_BAD_ADDR     = 3'd3;
	localparam logic [STAT_W-1:0] ST_ALREADY_FREE = 3'd4;
endpackage
`default_nettype wire

[hdl/first_fit_block_allocator_top.sv]
// First-fit block allocator: header memory, chain walk, split and merge sequencer.
// After reset a clearing pass writes every header entry, with busy high.
// Allocate walks the chain from address 0 to the first free block that fits and splits off the rest
// as a free block if a header fits; no fit by the chain end gives no space. Too large or bad range end
// at accept. Free marks the block free, then a merge walk from 0 absorbs free blocks following one.
// One result per item on done for one cycle; busy drops with done; the receiver cannot stall.
`default_nettype none
module first_fit_block_allocator_top #(
	parameter int ARENA_BYTES  = ffba_pkg::ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         operation,
	input  wire logic [ffba_pkg::SIZE_W-1:0]  request_size,
	input  wire logic [ffba_pkg::ADDR_W-1:0]  block_address,
	output logic                              done,
	output logic [ffba_pkg::ADDR_W-1:0]       granted_address,
	output logic [ffba_pkg::STAT_W-1:0]       status
);
	import ffba_pkg::*;

	localparam int AW = $clog2(ARENA_BYTES);
	localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
	localparam logic [CW-1:0] LIMIT = CW'(ARENA_BYTES - HEADER_BYTES);
	localparam logic [CW-1:0] ARENA = CW'(ARENA_BYTES);
	localparam logic [CW-1:0] HDR   = CW'(HEADER_BYTES);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_A_RD  = 4'd2;
	localparam logic [3:0] S_A_CHK = 4'd3;
	localparam logic [3:0] S_A_SPL = 4'd4;
	localparam logic [3:0] S_A_WR  = 4'd5;
	localparam logic [3:0] S_F_RD  = 4'd6;
	localparam logic [3:0] S_F_CHK = 4'd7;
	localparam logic [3:0] S_F_WR  = 4'd8;
	localparam logic [3:0] S_M_RD  = 4'd9;
	localparam logic [3:0] S_M_CHK = 4'd10;
	localparam logic [3:0] S_M_ARD = 4'd11;
	localparam logic [3:0] S_M_ABS = 4'd12;
	localparam logic [3:0] S_M_WR  = 4'd13;

	typedef struct packed {
		logic          blk_start;
		logic          blk_free;
		logic [AW-1:0] size;
		logic          linked;
		logic [AW-1:0] link;
	} entry_t;

	function automatic logic [AW-1:0] gap_of(entry_t e, logic [AW-1:0] at);
		logic [CW-1:0] endp;
		endp = e.linked ? CW'(e.link) : ARENA;
		return AW'(endp - CW'(at) - HDR);
	endfunction

	entry_t mem [ARENA_BYTES];
	entry_t mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	entry_t        mem_wd;
	logic [AW-1:0] mem_ra;

	logic [3:0]          st_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       cur_q;
	logic [SIZE_W-1:0]   req_q;
	entry_t              ent_q;
	entry_t              spl_q;
	logic [AW-1:0]       spl_addr_q;
	logic                done_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [STAT_W-1:0]   stat_q;

	entry_t        e;
	logic          fit;
	logic [CW-1:0] spl;
	logic [CW-1:0] cur_w;
	logic [CW-1:0] at_w;

	assign e     = mem_rd_q;
	assign fit   = e.blk_free && (CW'(e.size) >= CW'(req_q));
	assign spl   = CW'(cur_q) + CW'(req_q) + HDR;
	assign cur_w = CW'(cur_q);
	assign at_w  = CW'(block_address);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cur_q;
		mem_wd = ent_q;
		mem_ra = cur_q;
		unique case (st_q)
			S_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
				if (clr_q == '0) begin
					mem_wd.blk_start = 1'b1;
					mem_wd.blk_free  = 1'b1;
					mem_wd.size      = AW'(LIMIT);
				end
			end
			S_A_SPL: begin
				mem_we = 1'b1;
				mem_wa = spl_addr_q;
				mem_wd = spl_q;
			end
			S_A_WR, S_F_WR, S_M_WR: begin
				mem_we = 1'b1;
			end
			S_M_ARD: begin
				mem_ra = ent_q.link;
			end
			S_M_ABS: begin
				mem_we = e.blk_free;
				mem_wa = ent_q.link;
				mem_wd = e;
				mem_wd.blk_start = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLR;
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ARENA_BYTES - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q <= request_size;
						if (!operation) begin
							cur_q <= '0;
							if (CW'(request_size) > LIMIT) begin
								done_q <= 1'b1;
								addr_q <= '0;
								stat_q <= ST_TOO_LARGE;
							end else begin
								st_q <= S_A_RD;
							end
						end else begin
							cur_q <= at_w[AW-1:0];
							if (at_w > LIMIT) begin
								done_q <= 1'b1;
								addr_q <= '0;
								stat_q <= ST_BAD_ADDR;
							end else begin
								st_q <= S_F_RD;
							end
						end
					end
				end
				S_A_RD: begin
					st_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (!e.linked || fit) begin
						if (!fit) begin
							done_q <= 1'b1;
							addr_q <= '0;
							stat_q <= ST_NO_SPACE;
							st_q   <= S_IDLE;
						end else begin
							ent_q          <= e;
							ent_q.blk_free <= 1'b0;
							ent_q.size     <= AW'(req_q);
							spl_addr_q     <= spl[AW-1:0];
							spl_q.blk_start <= 1'b1;
							spl_q.blk_free  <= 1'b1;
							st_q           <= S_A_WR;
							if (!e.linked) begin
								if (spl <= LIMIT) begin
									spl_q.size   <= AW'(ARENA - spl - HDR);
									spl_q.linked <= 1'b0;
									spl_q.link   <= '0;
									ent_q.linked <= 1'b1;
									ent_q.link   <= spl[AW-1:0];
									st_q         <= S_A_SPL;
								end
							end else if (spl + HDR <= CW'(e.link)) begin
								spl_q.size   <= AW'(CW'(e.link) - spl - HDR);
								spl_q.linked <= 1'b1;
								spl_q.link   <= e.link;
								ent_q.link   <= spl[AW-1:0];
								st_q         <= S_A_SPL;
							end
						end
					end else begin
						cur_q <= e.link;
						st_q  <= S_A_RD;
					end
				end
				S_A_SPL: begin
					st_q <= S_A_WR;
				end
				S_A_WR: begin
					done_q <= 1'b1;
					addr_q <= cur_w[ADDR_W-1:0];
					stat_q <= ST_OK;
					st_q   <= S_IDLE;
				end
				S_F_RD: begin
					st_q <= S_F_CHK;
				end
				S_F_CHK: begin
					priority if (!e.blk_start) begin
						done_q <= 1'b1;
						addr_q <= '0;
						stat_q <= ST_BAD_ADDR;
						st_q   <= S_IDLE;
					end else if (e.blk_free) begin
						done_q <= 1'b1;
						addr_q <= '0;
						stat_q <= ST_ALREADY_FREE;
						st_q   <= S_IDLE;
					end else begin
						ent_q          <= e;
						ent_q.blk_free <= 1'b1;
						ent_q.size     <= gap_of(e, cur_q);
						st_q           <= S_F_WR;
					end
				end
				S_F_WR: begin
					cur_q <= '0;
					st_q  <= S_M_RD;
				end
				S_M_RD: begin
					st_q <= S_M_CHK;
				end
				S_M_CHK: begin
					ent_q <= e;
					priority if (e.blk_free && e.linked) begin
						st_q <= S_M_ARD;
					end else if (e.blk_free) begin
						ent_q.size <= gap_of(e, cur_q);
						st_q       <= S_M_WR;
					end else if (e.linked) begin
						cur_q <= e.link;
						st_q  <= S_M_RD;
					end else begin
						done_q <= 1'b1;
						addr_q <= '0;
						stat_q <= ST_OK;
						st_q   <= S_IDLE;
					end
				end
				S_M_ARD: begin
					st_q <= S_M_ABS;
				end
				S_M_ABS: begin
					if (e.blk_free) begin
						ent_q.linked <= e.linked;
						ent_q.link   <= e.link;
						if (e.linked) begin
							st_q <= S_M_ARD;
						end else begin
							ent_q.size <= AW'(ARENA - cur_w - HDR);
							st_q       <= S_M_WR;
						end
					end else begin
						ent_q.size <= gap_of(ent_q, cur_q);
						st_q       <= S_M_WR;
					end
				end
				S_M_WR: begin
					if (ent_q.linked) begin
						cur_q <= ent_q.link;
						st_q  <= S_M_RD;
					end else begin
						done_q <= 1'b1;
						addr_q <= '0;
						stat_q <= ST_OK;
						st_q   <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (st_q != S_IDLE);
	assign done            = done_q;
	assign granted_address = addr_q;
	assign status          = stat_q;

`ifndef ASSERT_OFF
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_TOO_LARGE || status == ST_NO_SPACE ||
			status == ST_BAD_ADDR || status == ST_ALREADY_FREE))
		else $error("result status out of range");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> granted_address == '0)
		else $error("error result carries an address");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while sequencer is active");
	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_CLR |-> !done)
		else $error("result during clearing pass");
`endif
endmodule
`default_nettype wire
